@@ src/tcce_pkg.sv @@
`timescale 1ns / 1ps
package tcce_pkg;

  localparam int DEF_MAX_SCREEN_WIDTH  = 4096;
  localparam int DEF_MAX_SCREEN_HEIGHT = 4096;

  localparam int DIM_W      = 13;
  localparam int ROW_W      = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 120;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] RESET_SCREEN_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0] RESET_SCREEN_HEIGHT = 13'd768;
  localparam int               MIN_DIM             = 16;

  localparam int CELL_W = 9;
  localparam int CELL_H = 16;

  localparam logic [ROW_W-1:0] ROW_MAX = 9'd511;

  // floor(w / 9) == (w * RECIP9) >> RECIP_SHIFT for all w below 2**13
  localparam logic [DIM_W-1:0] RECIP9      = 13'd7282;
  localparam int               RECIP_SHIFT = 16;

  localparam int               TAB_CNT_W = 3;
  localparam logic [TAB_CNT_W-1:0] TAB_LAST = 3'd7;

  localparam logic [7:0] CHAR_BS = 8'd8;
  localparam logic [7:0] CHAR_HT = 8'd9;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [2:0] {
    OP_CHAR = 3'd0,
    OP_LF   = 3'd1,
    OP_CR   = 3'd2,
    OP_BS   = 3'd3,
    OP_TAB  = 3'd4,
    OP_EOT  = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  code;
    logic [31:0] color;
  } op_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } screen_cfg_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       glyph;
    logic [31:0]      draw_color;
    logic [11:0]      pixel_x;
    logic [11:0]      pixel_y;
    logic             scroll_first;
    logic [DIM_W-1:0] region_left;
    logic [DIM_W-1:0] region_top;
    logic [DIM_W-1:0] region_right;
    logic [DIM_W-1:0] region_bottom;
    logic             last;
  } result_t;

endpackage

@@ src/tcce_front.sv @@
`timescale 1ns / 1ps
module tcce_front (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tcce_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           q_full,
  output logic                           push,
  output tcce_pkg::op_t                  push_op
);

  logic [7:0] code;

  assign code      = in_tdata[7:0];
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    push_op.code  = code;
    push_op.color = in_tdata[39:8];
    if (in_tuser) begin
      push_op.kind = tcce_pkg::OP_EOT;
    end else begin
      unique case (code)
        tcce_pkg::CHAR_LF: push_op.kind = tcce_pkg::OP_LF;
        tcce_pkg::CHAR_CR: push_op.kind = tcce_pkg::OP_CR;
        tcce_pkg::CHAR_BS: push_op.kind = tcce_pkg::OP_BS;
        tcce_pkg::CHAR_HT: push_op.kind = tcce_pkg::OP_TAB;
        default:           push_op.kind = tcce_pkg::OP_CHAR;
      endcase
    end
  end

endmodule

@@ src/tcce_queue.sv @@
`timescale 1ns / 1ps
module tcce_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcce_pkg::op_t push_op,
  output logic          full,
  output logic          head_valid,
  output tcce_pkg::op_t head_op,
  input  logic          pop
);

  tcce_pkg::op_t               mem_r [tcce_pkg::QDEPTH];
  logic [tcce_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [tcce_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [tcce_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                        do_pop;

  assign full       = count_r == (tcce_pkg::QPTR_W + 1)'(tcce_pkg::QDEPTH);
  assign head_valid = count_r != '0;
  assign head_op    = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

@@ src/tcce_back.sv @@
`timescale 1ns / 1ps
module tcce_back #(
  parameter int MAX_SCREEN_WIDTH  = tcce_pkg::DEF_MAX_SCREEN_WIDTH,
  parameter int MAX_SCREEN_HEIGHT = tcce_pkg::DEF_MAX_SCREEN_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcce_pkg::screen_cfg_t cfg,
  input  logic                  head_valid,
  input  tcce_pkg::op_t         head_op,
  output logic                  pop,
  input  logic                  out_ready,
  output logic                  out_valid,
  output tcce_pkg::result_t     out_res
);

  localparam int DIM_W = tcce_pkg::DIM_W;
  localparam int LIM_W = DIM_W + 1;
  localparam int ROW_W = tcce_pkg::ROW_W;
  localparam int COL_W = $clog2(MAX_SCREEN_WIDTH / tcce_pkg::CELL_W + 1);
  localparam logic [LIM_W-1:0] MAX_W_L = LIM_W'(MAX_SCREEN_WIDTH);
  localparam logic [LIM_W-1:0] MAX_H_L = LIM_W'(MAX_SCREEN_HEIGHT);
  localparam logic [LIM_W-1:0] MIN_L   = LIM_W'(tcce_pkg::MIN_DIM);

  logic [COL_W-1:0]               col_r, col_nxt;
  logic [ROW_W-1:0]               row_r, row_nxt;
  logic                           box_valid_r, box_valid_nxt;
  logic [DIM_W-1:0]               box_left_r, box_left_nxt;
  logic [DIM_W-1:0]               box_top_r, box_top_nxt;
  logic [DIM_W-1:0]               box_right_r, box_right_nxt;
  logic [DIM_W-1:0]               box_bottom_r, box_bottom_nxt;
  logic [tcce_pkg::TAB_CNT_W-1:0] tab_cnt_r, tab_cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  tcce_pkg::result_t              out_res_r, out_res_nxt;

  logic [LIM_W-1:0]   w_ext, h_ext, eff_w_ext, eff_h_ext;
  logic [DIM_W-1:0]   eff_w, eff_h;
  logic [2*DIM_W-1:0] cols_prod;
  logic [COL_W-1:0]   cols;
  logic [ROW_W-1:0]   rows;

  logic             wrap, scroll;
  logic [COL_W-1:0] col_a, col_m1;
  logic [ROW_W-1:0] row_inc, row_a, row_b;
  logic [DIM_W-1:0] px, py;
  logic [LIM_W-1:0] px_end, py_end, right_m, bottom_m;
  logic [DIM_W-1:0] m_left, m_top, m_right, m_bottom;

  logic              out_free, step, draw, draw_last, emit;
  tcce_pkg::result_t res;

  // effective screen size and cell grid
  always_comb begin
    w_ext = {1'b0, cfg.width};
    h_ext = {1'b0, cfg.height};
    if (w_ext < MIN_L) begin
      eff_w_ext = MIN_L;
    end else if (w_ext > MAX_W_L) begin
      eff_w_ext = MAX_W_L;
    end else begin
      eff_w_ext = w_ext;
    end
    if (h_ext < MIN_L) begin
      eff_h_ext = MIN_L;
    end else if (h_ext > MAX_H_L) begin
      eff_h_ext = MAX_H_L;
    end else begin
      eff_h_ext = h_ext;
    end
  end

  assign eff_w     = eff_w_ext[DIM_W-1:0];
  assign eff_h     = eff_h_ext[DIM_W-1:0];
  assign cols_prod = eff_w * tcce_pkg::RECIP9;
  assign cols      = cols_prod[tcce_pkg::RECIP_SHIFT +: COL_W];
  assign rows      = eff_h[DIM_W-1:4];

  // one cursor advance and the cell it draws
  always_comb begin
    wrap    = col_r >= cols;
    row_inc = (row_r == tcce_pkg::ROW_MAX) ? row_r : row_r + 1'b1;
    col_a   = wrap ? COL_W'(1) : col_r + 1'b1;
    row_a   = wrap ? row_inc : row_r;
    scroll  = row_a >= rows;
    row_b   = scroll ? rows - 1'b1 : row_a;
    col_m1  = col_a - 1'b1;
    px      = (DIM_W'(col_m1) << 3) + DIM_W'(col_m1);
    py      = {row_b, 4'b0000};
    px_end  = {1'b0, px} + LIM_W'(tcce_pkg::CELL_W);
    py_end  = {1'b0, py} + LIM_W'(tcce_pkg::CELL_H);

    if (scroll) begin
      m_left   = '0;
      m_top    = '0;
      right_m  = '0;
      bottom_m = '0;
      m_right  = eff_w;
      m_bottom = eff_h;
    end else begin
      if (box_valid_r) begin
        m_left   = (px < box_left_r) ? px : box_left_r;
        m_top    = (py < box_top_r) ? py : box_top_r;
        right_m  = (px_end > {1'b0, box_right_r}) ? px_end : {1'b0, box_right_r};
        bottom_m = (py_end > {1'b0, box_bottom_r}) ? py_end : {1'b0, box_bottom_r};
      end else begin
        m_left   = px;
        m_top    = py;
        right_m  = px_end;
        bottom_m = py_end;
      end
      m_right  = (right_m > eff_w_ext) ? eff_w : right_m[DIM_W-1:0];
      m_bottom = (bottom_m > eff_h_ext) ? eff_h : bottom_m[DIM_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign step     = head_valid && out_free;

  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    box_valid_nxt  = box_valid_r;
    box_left_nxt   = box_left_r;
    box_top_nxt    = box_top_r;
    box_right_nxt  = box_right_r;
    box_bottom_nxt = box_bottom_r;
    tab_cnt_nxt    = tab_cnt_r;
    pop            = 1'b0;
    draw           = 1'b0;
    draw_last      = 1'b0;
    emit           = 1'b0;
    res            = '0;

    if (step) begin
      unique case (head_op.kind)
        tcce_pkg::OP_EOT: begin
          pop = 1'b1;
          if (box_valid_r && box_right_r > box_left_r && box_bottom_r > box_top_r) begin
            emit              = 1'b1;
            res.kind          = 1'b1;
            res.region_left   = box_left_r;
            res.region_top    = box_top_r;
            res.region_right  = box_right_r;
            res.region_bottom = box_bottom_r;
            res.last          = 1'b1;
            box_valid_nxt     = 1'b0;
          end
        end
        tcce_pkg::OP_LF: begin
          pop     = 1'b1;
          row_nxt = row_inc;
          col_nxt = '0;
        end
        tcce_pkg::OP_CR: begin
          pop     = 1'b1;
          col_nxt = '0;
        end
        tcce_pkg::OP_BS: begin
          pop = 1'b1;
          if (col_r != '0) begin
            col_nxt = col_r - 1'b1;
          end else begin
            draw      = 1'b1;
            draw_last = 1'b1;
          end
        end
        tcce_pkg::OP_TAB: begin
          draw        = 1'b1;
          draw_last   = tab_cnt_r == tcce_pkg::TAB_LAST;
          pop         = draw_last;
          tab_cnt_nxt = tab_cnt_r + 1'b1;
        end
        tcce_pkg::OP_CHAR: begin
          pop       = 1'b1;
          draw      = 1'b1;
          draw_last = 1'b1;
        end
        default: begin
          pop = 1'b1;
        end
      endcase

      if (draw) begin
        col_nxt            = col_a;
        row_nxt            = row_b;
        box_valid_nxt      = 1'b1;
        box_left_nxt       = m_left;
        box_top_nxt        = m_top;
        box_right_nxt      = m_right;
        box_bottom_nxt     = m_bottom;
        emit               = 1'b1;
        res.glyph          = head_op.code;
        res.draw_color     = head_op.color;
        res.pixel_x        = px[11:0];
        res.pixel_y        = py[11:0];
        res.scroll_first   = scroll;
        res.last           = draw_last;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_free) begin
      out_valid_nxt = emit;
      if (emit) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      box_valid_r  <= 1'b0;
      box_left_r   <= '0;
      box_top_r    <= '0;
      box_right_r  <= '0;
      box_bottom_r <= '0;
      tab_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      box_valid_r  <= box_valid_nxt;
      box_left_r   <= box_left_nxt;
      box_top_r    <= box_top_nxt;
      box_right_r  <= box_right_nxt;
      box_bottom_r <= box_bottom_nxt;
      tab_cnt_r    <= tab_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

@@ src/text_console_cursor_engine.sv @@
`timescale 1ns / 1ps
// Results pass through the request queue and the output register before they appear on
// out_tvalid. The block takes one request per cycle while out_tready does not stall it; a tab
// yields 8 draws, while the 4-deep request queue keeps taking input until it is full.
// Reset (rst_n, synchronous, active low): screen 1024x768, cursor at column 0, row 0,
// dirty box empty, queue and output register empty.
module text_console_cursor_engine #(
  parameter int MAX_SCREEN_WIDTH  = tcce_pkg::DEF_MAX_SCREEN_WIDTH,
  parameter int MAX_SCREEN_HEIGHT = tcce_pkg::DEF_MAX_SCREEN_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // char_code [7:0], ink_color [39:8]
  input  logic [tcce_pkg::IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // glyph [7:0], draw_color [39:8], pixel_x [51:40], pixel_y [63:52],
  // scroll_first [64], region_left [77:65], region_top [90:78],
  // region_right [103:91], region_bottom [116:104], zero [119:117]
  output logic [tcce_pkg::OUT_DATA_W-1:0] out_tdata,
  // kind
  output logic                            out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcce_pkg::DIM_W-1:0]      cfg_wr_data
);

  tcce_pkg::screen_cfg_t cfg_r, cfg_nxt;
  logic                  q_full, push, head_valid, pop;
  tcce_pkg::op_t         push_op, head_op;
  tcce_pkg::result_t     res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        tcce_pkg::REG_SCREEN_WIDTH:  cfg_nxt.width  = cfg_wr_data;
        tcce_pkg::REG_SCREEN_HEIGHT: cfg_nxt.height = cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= tcce_pkg::RESET_SCREEN_WIDTH;
      cfg_r.height <= tcce_pkg::RESET_SCREEN_HEIGHT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcce_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop)
  );

  tcce_back #(
    .MAX_SCREEN_WIDTH  (MAX_SCREEN_WIDTH),
    .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_res    (res)
  );

  assign out_tdata = {3'b000, res.region_bottom, res.region_right, res.region_top,
                      res.region_left, res.scroll_first, res.pixel_y, res.pixel_x,
                      res.draw_color, res.glyph};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  // a refresh region is always the only result of its request
  a_region_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("refresh region without tlast");

  // a refresh region is never empty
  a_region_area: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      (res.region_right > res.region_left) && (res.region_bottom > res.region_top))
    else $error("empty refresh region");

  // pop only from a non-empty queue
  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop on empty queue");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

@@ dv/tb_text_console_cursor_engine.sv @@
`timescale 1ns / 1ps
module tb_text_console_cursor_engine;

  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_EOT = 1'b1;
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_REGION = 1'b1;
  localparam int TAB_DRAWS     = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD     = 300;
  localparam int HOLD_AT       = 200;
  localparam int IDLE_LIMIT    = 3000;
  localparam int TAIL_CYCLES   = 20;
  localparam int LF_BURST      = 60;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 40;

  typedef enum logic [1:0] {FE_REQ, FE_CFG, FE_SYNC, FE_CALM} feed_kind_t;

  typedef struct {
    feed_kind_t                     kind;
    logic                           action;
    logic [7:0]                     code;
    logic [31:0]                    color;
    logic [tcce_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [tcce_pkg::DIM_W-1:0]     reg_val;
    bit                             calm;
  } feed_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [tcce_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                            in_tuser = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [tcce_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tuser;
  logic                            out_tlast;
  logic                            cfg_wr_en = 1'b0;
  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tcce_pkg::DIM_W-1:0]      cfg_wr_data = '0;

  text_console_cursor_engine DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  feed_t             feed_q[$];
  tcce_pkg::result_t cmd_q[$];
  feed_t             cur_feed;
  int      fail_count = 0;
  int      reqs_taken = 0;
  int      cmds_seen = 0;
  int      gap_cnt = 0;
  int      settle_cnt = 0;
  int      hold_cnt = 0;
  int      idle_cycles = 0;
  bit      calm_mode = 1'b0;
  bit      long_hold_done = 1'b0;

  // shadow of the block
  int scr_w = tcce_pkg::RESET_SCREEN_WIDTH;
  int scr_h = tcce_pkg::RESET_SCREEN_HEIGHT;
  int cur_col = 0;
  int cur_row = 0;
  bit box_valid = 1'b0;
  int box_l = 0, box_t = 0, box_r = 0, box_b = 0;

  task automatic report_mismatch(input string msg);
    if (fail_count < 100) $display("MISMATCH at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("command %0d %s: got 0x%0h, want 0x%0h",
                                cmds_seen, name, got, want));
  endtask

  function automatic int clamp_dim(input int v, input int hi);
    if (v < tcce_pkg::MIN_DIM) return tcce_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int next_row(input int r);
    return (r >= int'(tcce_pkg::ROW_MAX)) ? int'(tcce_pkg::ROW_MAX) : r + 1;
  endfunction

  task automatic grow_box(input int x, input int y, input int w, input int h);
    int ew, eh;
    ew = clamp_dim(scr_w, tcce_pkg::DEF_MAX_SCREEN_WIDTH);
    eh = clamp_dim(scr_h, tcce_pkg::DEF_MAX_SCREEN_HEIGHT);
    if (!box_valid) begin
      box_l = x;
      box_t = y;
      box_r = x + w;
      box_b = y + h;
      box_valid = 1'b1;
    end else begin
      if (x < box_l) box_l = x;
      if (y < box_t) box_t = y;
      if (x + w > box_r) box_r = x + w;
      if (y + h > box_b) box_b = y + h;
    end
    if (box_r > ew) box_r = ew;
    if (box_b > eh) box_b = eh;
  endtask

  task automatic draw_cell(input logic [7:0] glyph, input logic [31:0] color,
                           input bit last_one);
    int w, h, cols, rows, px, py;
    bit scroll;
    tcce_pkg::result_t c;
    w = clamp_dim(scr_w, tcce_pkg::DEF_MAX_SCREEN_WIDTH);
    h = clamp_dim(scr_h, tcce_pkg::DEF_MAX_SCREEN_HEIGHT);
    cols = w / tcce_pkg::CELL_W;
    rows = h / tcce_pkg::CELL_H;
    scroll = 1'b0;
    if (cur_col >= cols) begin
      cur_col = 1;
      cur_row = next_row(cur_row);
    end else begin
      cur_col++;
    end
    if (cur_row >= rows) begin
      cur_row = rows - 1;
      scroll = 1'b1;
      grow_box(0, 0, w, h);
    end
    px = (cur_col - 1) * tcce_pkg::CELL_W;
    py = cur_row * tcce_pkg::CELL_H;
    grow_box(px, py, tcce_pkg::CELL_W, tcce_pkg::CELL_H);
    c = '0;
    c.kind = KIND_DRAW;
    c.glyph = glyph;
    c.draw_color = color;
    c.pixel_x = px[11:0];
    c.pixel_y = py[11:0];
    c.scroll_first = scroll;
    c.last = last_one;
    cmd_q.push_back(c);
  endtask

  task automatic cursor_engine_step(input feed_t f);
    tcce_pkg::result_t c;
    if (f.action == ACT_EOT) begin
      if (box_valid && box_r > box_l && box_b > box_t) begin
        c = '0;
        c.kind = KIND_REGION;
        c.region_left = box_l[tcce_pkg::DIM_W-1:0];
        c.region_top = box_t[tcce_pkg::DIM_W-1:0];
        c.region_right = box_r[tcce_pkg::DIM_W-1:0];
        c.region_bottom = box_b[tcce_pkg::DIM_W-1:0];
        c.last = 1'b1;
        cmd_q.push_back(c);
        box_valid = 1'b0;
      end
    end else if (f.code == tcce_pkg::CHAR_LF) begin
      cur_row = next_row(cur_row);
      cur_col = 0;
    end else if (f.code == tcce_pkg::CHAR_CR) begin
      cur_col = 0;
    end else if (f.code == tcce_pkg::CHAR_BS && cur_col > 0) begin
      cur_col--;
    end else if (f.code == tcce_pkg::CHAR_HT) begin
      for (int i = 0; i < TAB_DRAWS; i++)
        draw_cell(tcce_pkg::CHAR_HT, f.color, i == TAB_DRAWS - 1);
    end else begin
      draw_cell(f.code, f.color, 1'b1);
    end
  endtask

  function automatic int pick_gap(input bit calm_now);
    int r;
    if (calm_now) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver
  always @(posedge clk) begin : feed_driver
    bit offering;
    bit wr;
    offering = in_tvalid;
    wr = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        cursor_engine_step(cur_feed);
        reqs_taken++;
        offering = 1'b0;
        gap_cnt = pick_gap(calm_mode);
      end
      if (!offering && feed_q.size() != 0) begin
        case (feed_q[0].kind)
          FE_REQ: begin
            if (gap_cnt > 0) begin
              gap_cnt--;
            end else begin
              cur_feed = feed_q.pop_front();
              in_tdata <= {cur_feed.color, cur_feed.code};
              in_tuser <= cur_feed.action;
              offering = 1'b1;
            end
          end
          FE_CALM: begin
            calm_mode = feed_q[0].calm;
            feed_q.delete(0);
          end
          default: begin
            if (cmd_q.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt < SETTLE_CYCLES) begin
              settle_cnt++;
            end else begin
              settle_cnt = 0;
              if (feed_q[0].kind == FE_CFG) begin
                wr = 1'b1;
                cfg_index <= feed_q[0].reg_idx;
                cfg_wr_data <= feed_q[0].reg_val;
                if (feed_q[0].reg_idx == tcce_pkg::REG_SCREEN_WIDTH) scr_w = feed_q[0].reg_val;
                else scr_h = feed_q[0].reg_val;
              end
              feed_q.delete(0);
            end
          end
        endcase
      end
    end
    in_tvalid <= offering;
    cfg_wr_en <= wr;
  end

  // result receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!long_hold_done && reqs_taken >= HOLD_AT) begin
      long_hold_done = 1'b1;
      hold_cnt = LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (calm_mode || $urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      hold_cnt = pick_gap(1'b0);
      out_tready <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin : cmd_monitor
    tcce_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cmd_q.size() == 0) begin
        report_mismatch($sformatf("command %0d arrived with nothing expected", cmds_seen));
      end else begin
        want = cmd_q.pop_front();
        check_field("kind", out_tuser, want.kind);
        check_field("glyph", out_tdata[7:0], want.glyph);
        check_field("draw_color", out_tdata[39:8], want.draw_color);
        check_field("pixel_x", out_tdata[51:40], want.pixel_x);
        check_field("pixel_y", out_tdata[63:52], want.pixel_y);
        check_field("scroll_first", out_tdata[64], want.scroll_first);
        check_field("region_left", out_tdata[77:65], want.region_left);
        check_field("region_top", out_tdata[90:78], want.region_top);
        check_field("region_right", out_tdata[103:91], want.region_right);
        check_field("region_bottom", out_tdata[116:104], want.region_bottom);
        check_field("last", out_tlast, want.last);
      end
      cmds_seen++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_request(input logic action, input logic [7:0] code,
                              input logic [31:0] color);
    feed_t f;
    f = '{kind: FE_REQ, action: action, code: code, color: color,
          reg_idx: '0, reg_val: '0, calm: 1'b0};
    feed_q.push_back(f);
  endtask

  task automatic push_config(input logic [tcce_pkg::CFG_IDX_W-1:0] idx, input int val);
    feed_t f;
    f = '{kind: FE_CFG, action: ACT_PUT, code: '0, color: '0,
          reg_idx: idx, reg_val: val[tcce_pkg::DIM_W-1:0], calm: 1'b0};
    feed_q.push_back(f);
  endtask

  task automatic push_marker(input feed_kind_t kind, input bit calm);
    feed_t f;
    f = '{kind: kind, action: ACT_PUT, code: '0, color: '0,
          reg_idx: '0, reg_val: '0, calm: calm};
    feed_q.push_back(f);
  endtask

  function automatic int rand_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 31);
    if (r == 1) return $urandom_range(4090, 8191);
    if (r < 7) return $urandom_range(16, 200);
    return $urandom_range(16, 4096);
  endfunction

  task automatic push_random_request();
    int r;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    code = $urandom_range(0, 255);
    if (r < 10) begin
      push_request(ACT_EOT, code, $urandom);
    end else begin
      if (r < 16) code = tcce_pkg::CHAR_LF;
      else if (r < 20) code = tcce_pkg::CHAR_CR;
      else if (r < 25) code = tcce_pkg::CHAR_BS;
      else if (r < 30) code = tcce_pkg::CHAR_HT;
      push_request(ACT_PUT, code, $urandom);
    end
  endtask

  initial begin
    // default screen, field extremes and every control character
    push_request(ACT_EOT, 8'hFF, 32'hFFFF_FFFF);
    push_request(ACT_PUT, 8'h41, 32'hFFFF_FFFF);
    push_request(ACT_PUT, 8'h00, 32'h0000_0000);
    push_request(ACT_PUT, 8'hFF, 32'h5A5A_5A5A);
    push_request(ACT_PUT, tcce_pkg::CHAR_HT, 32'h1234_5678);
    push_request(ACT_PUT, tcce_pkg::CHAR_BS, 32'hA5A5_A5A5);
    push_request(ACT_PUT, tcce_pkg::CHAR_CR, 32'h0);
    push_request(ACT_PUT, tcce_pkg::CHAR_BS, 32'hDEAD_BEEF);
    push_request(ACT_PUT, tcce_pkg::CHAR_LF, 32'h0);
    push_request(ACT_PUT, 8'h7A, 32'h0F0F_0F0F);
    push_request(ACT_EOT, 8'h00, 32'h0);
    push_request(ACT_EOT, 8'h00, 32'h0);
    // below the minimum: one column, one row, every draw scrolls
    push_config(tcce_pkg::REG_SCREEN_WIDTH, 0);
    push_config(tcce_pkg::REG_SCREEN_HEIGHT, 15);
    push_request(ACT_PUT, 8'h61, 32'h8000_0001);
    push_request(ACT_PUT, 8'h62, 32'h7FFF_FFFE);
    push_request(ACT_PUT, tcce_pkg::CHAR_HT, 32'hC3C3_C3C3);
    push_request(ACT_EOT, 8'h00, 32'h0);
    // above the maximum, then shrink with the cursor and box far right
    push_config(tcce_pkg::REG_SCREEN_WIDTH, 8191);
    push_config(tcce_pkg::REG_SCREEN_HEIGHT, 4096);
    repeat (5) push_request(ACT_PUT, tcce_pkg::CHAR_HT, 32'h3C3C_3C3C);
    push_config(tcce_pkg::REG_SCREEN_WIDTH, 200);
    push_request(ACT_EOT, 8'h00, 32'h0);
    push_request(ACT_PUT, 8'h78, 32'h1111_1111);
    push_config(tcce_pkg::REG_SCREEN_WIDTH, 4096);
    push_config(tcce_pkg::REG_SCREEN_HEIGHT, 8191);
    push_request(ACT_PUT, 8'h80, 32'h2222_2222);
    push_config(tcce_pkg::REG_SCREEN_WIDTH, 17);
    push_config(tcce_pkg::REG_SCREEN_HEIGHT, 16);
    push_request(ACT_PUT, 8'h7F, 32'h4444_4444);
    push_request(ACT_EOT, 8'h00, 32'h0);
    push_marker(FE_SYNC, 1'b0);

    // a run of line feeds well past the last row
    push_config(tcce_pkg::REG_SCREEN_WIDTH, 1024);
    push_config(tcce_pkg::REG_SCREEN_HEIGHT, 768);
    push_marker(FE_CALM, 1'b1);
    repeat (LF_BURST) push_request(ACT_PUT, tcce_pkg::CHAR_LF, $urandom);
    push_request(ACT_PUT, 8'h51, 32'h9999_9999);
    push_request(ACT_EOT, 8'h00, 32'h0);
    push_marker(FE_CALM, 1'b0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      push_config(tcce_pkg::REG_SCREEN_WIDTH, rand_dim());
      push_config(tcce_pkg::REG_SCREEN_HEIGHT, rand_dim());
      push_marker(FE_CALM, p == 3);
      repeat (PHASE_ITEMS) push_random_request();
      if (p == 5) push_marker(FE_SYNC, 1'b0);
    end
    push_marker(FE_CALM, 1'b0);

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (feed_q.size() != 0 || in_tvalid || cmd_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (cmd_q.size() != 0)
      report_mismatch($sformatf("%0d expected commands never arrived", cmd_q.size()));
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ text_console_cursor_engine.f @@
src/tcce_pkg.sv
src/tcce_front.sv
src/tcce_queue.sv
src/tcce_back.sv
src/text_console_cursor_engine.sv
dv/tb_text_console_cursor_engine.sv
